@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the RTL of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge while reset is released.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Property checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

@@ rtl/rc4fb_pkg.sv @@
// ----------------------------------------------------------------------------
// rc4fb_pkg
// Types and constants of the feedback stream cipher core.
// ----------------------------------------------------------------------------
package rc4fb_pkg;

    typedef logic [7:0] t_byte;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_SECRET_LOW  = 2'd0,
        CFG_SECRET_HIGH = 2'd1,
        CFG_KEY_LENGTH  = 2'd2
    } t_cfg_index;

    localparam int unsigned TABLE_DEPTH = 256;
    localparam int unsigned KEY_LEN_W   = 5;
    localparam int unsigned SECRET_W    = 64;

    // Sequencer states, one-hot.
    typedef enum logic [9:0] {
        ST_IDLE = 10'b00_0000_0001,
        ST_FILL = 10'b00_0000_0010,
        ST_KRI  = 10'b00_0000_0100,
        ST_KRJ  = 10'b00_0000_1000,
        ST_KWI  = 10'b00_0001_0000,
        ST_KWJ  = 10'b00_0010_0000,
        ST_PRD1 = 10'b00_0100_0000,
        ST_PRD2 = 10'b00_1000_0000,
        ST_SWAP = 10'b01_0000_0000,
        ST_FIN  = 10'b10_0000_0000
    } t_state;

endpackage

@@ rtl/rc4_feedback_stream_cipher_core.sv @@
// ----------------------------------------------------------------------------
// rc4_feedback_stream_cipher_core
// Byte-wide RC4-style stream cipher with plaintext feedback into index one.
// ----------------------------------------------------------------------------
// Each accepted byte is XORed with one keystream byte taken from a 256-entry
// permutation table held in a single memory with one write port and one
// registered read port. A byte that carries the first-of-message flag in
// tuser, the first byte after reset, and the first byte after a byte that
// carried tlast all run the key schedule first: the table is loaded with the
// identity and then mixed with the secret, one entry at a time, ahead of
// that byte. An ordinary byte is finished before the next input transfer
// is taken: the table lookup at index one, the lookup at index two, the
// swap and the keystream lookup each need their own memory access, and the
// last step waits while the output register is full. The result sits in an
// output register, so a new byte is taken while the previous result still
// waits for the downstream side. Configuration registers (secret bytes and
// key length) are written through a separate write channel and take effect
// at the next key schedule; write them only while the core is idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rc4_feedback_stream_cipher_core
    import rc4fb_pkg::*;
#(
    parameter int unsigned SECRET_MAX_BYTES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,

    // Plaintext stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] first_of_message
    input  logic        s_axis_tlast,

    // Ciphertext stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] cipher_byte
    output logic        m_axis_tlast
);

    // Width of the secret byte counter; at least one bit.
    localparam int unsigned SW = (SECRET_MAX_BYTES > 1) ? $clog2(SECRET_MAX_BYTES) : 1;
    localparam logic [KEY_LEN_W-1:0] KEY_LEN_MAX = KEY_LEN_W'(SECRET_MAX_BYTES);

    // Configuration registers.
    logic [SECRET_W-1:0]  r_secret_lo;
    logic [SECRET_W-1:0]  r_secret_hi;
    logic [KEY_LEN_W-1:0] r_key_len;

    // Sequencer and indices.
    t_state        r_state, n_state;
    t_byte         r_i;        // key schedule index, also fill counter
    t_byte         r_j;        // key schedule mixing index
    logic [SW-1:0] r_s;        // secret byte position
    t_byte         r_i1;       // index one
    t_byte         r_i2;       // index two
    logic          r_done;     // key schedule valid for the current message

    // Per-byte working registers.
    t_byte         r_data;
    logic          r_last;
    t_byte         r_a;
    t_byte         r_b;
    t_byte         r_t;

    // Output register.
    logic          r_out_valid;
    t_byte         r_out_data;
    logic          r_out_last;

    // Table memory port.
    logic          ram_we;
    t_byte         ram_waddr;
    t_byte         ram_wdata;
    t_byte         ram_raddr;
    t_byte         ram_rdata;

    logic [KEY_LEN_W-1:0] w_klen;
    logic [127:0]         w_secret;
    logic [3:0]           w_sidx;
    t_byte                w_key_byte;
    logic                 w_s_wrap;
    logic                 w_in_xfer;
    logic                 w_need_sched;
    t_byte                w_data_src;
    t_byte                w_i1_next;
    t_byte                w_i2_next;
    t_byte                w_t;
    t_byte                w_j_next;
    t_byte                w_ks;
    logic                 w_out_free;
    logic                 w_fin_fire;

    rc4fb_ram #(
        .WIDTH (8),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // A key length of zero behaves as one; lengths beyond the secret saturate.
    assign w_klen = (r_key_len == '0) ? KEY_LEN_W'(1) :
                    (r_key_len > KEY_LEN_MAX) ? KEY_LEN_MAX : r_key_len;

    assign w_secret   = {r_secret_hi, r_secret_lo};
    assign w_sidx     = 4'(r_s);
    assign w_key_byte = w_secret[{w_sidx, 3'b000} +: 8];
    assign w_s_wrap   = (KEY_LEN_W'(r_s) + KEY_LEN_W'(1)) >= w_klen;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign w_need_sched  = s_axis_tuser || !r_done;

    // In the idle state the plaintext comes straight from the port, so the
    // lookup at index one is issued in the cycle of the transfer itself.
    assign w_data_src = (r_state == ST_IDLE) ? s_axis_tdata : r_data;
    assign w_i1_next  = r_i1 + 8'd1 + w_data_src;
    assign w_i2_next  = r_i2 + ram_rdata;
    assign w_t        = r_a + ram_rdata;
    assign w_j_next   = r_j + w_key_byte + ram_rdata;

    // The keystream lookup overlaps the two swap writes, so entries that were
    // just swapped are forwarded. If both indices match, a equals b.
    always_comb begin
        if (r_t == r_i2) begin
            w_ks = r_a;
        end else if (r_t == r_i1) begin
            w_ks = r_b;
        end else begin
            w_ks = ram_rdata;
        end
    end

    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_fin_fire = (r_state == ST_FIN) && w_out_free;

    // Memory port steering.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_i;
        ram_wdata = r_i;
        ram_raddr = w_i1_next;
        unique case (r_state)
            ST_IDLE, ST_PRD1: begin
                ram_raddr = w_i1_next;
            end
            ST_FILL: begin
                ram_we = 1'b1;
            end
            ST_KRI: begin
                ram_raddr = r_i;
            end
            ST_KRJ: begin
                ram_raddr = w_j_next;
            end
            ST_KWI: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
            end
            ST_KWJ: begin
                ram_we    = 1'b1;
                ram_waddr = r_j;
                ram_wdata = r_a;
            end
            ST_PRD2: begin
                ram_raddr = w_i2_next;
            end
            ST_SWAP: begin
                ram_we    = 1'b1;
                ram_waddr = r_i1;
                ram_wdata = ram_rdata;
                ram_raddr = w_t;
            end
            ST_FIN: begin
                // Rewriting index two while stalled is harmless, and holding
                // the read address keeps the keystream entry on the port.
                ram_we    = 1'b1;
                ram_waddr = r_i2;
                ram_wdata = r_a;
                ram_raddr = r_t;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_xfer) begin
                    n_state = w_need_sched ? ST_FILL : ST_PRD2;
                end
            end
            ST_FILL: begin
                if (r_i == 8'hFF) begin
                    n_state = ST_KRI;
                end
            end
            ST_KRI:  n_state = ST_KRJ;
            ST_KRJ:  n_state = ST_KWI;
            ST_KWI:  n_state = ST_KWJ;
            ST_KWJ: begin
                n_state = (r_i == 8'hFF) ? ST_PRD1 : ST_KRI;
            end
            ST_PRD1: n_state = ST_PRD2;
            ST_PRD2: n_state = ST_SWAP;
            ST_SWAP: n_state = ST_FIN;
            ST_FIN: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_secret_lo <= '0;
            r_secret_hi <= '0;
            r_key_len   <= KEY_LEN_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SECRET_LOW:  r_secret_lo <= i_cfg_data;
                CFG_SECRET_HIGH: r_secret_hi <= i_cfg_data;
                CFG_KEY_LENGTH:  r_key_len   <= i_cfg_data[KEY_LEN_W-1:0];
                default: begin
                    // Unused index: the write is dropped.
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_i         <= '0;
            r_i1        <= '0;
            r_i2        <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (r_state == ST_IDLE && w_in_xfer && !w_need_sched) begin
                r_i1 <= w_i1_next;
            end
            if (r_state == ST_PRD1) begin
                r_i1 <= w_i1_next;
            end
            if (r_state == ST_FILL || r_state == ST_KWJ) begin
                r_i <= r_i + 8'd1;
            end
            if (r_state == ST_KWJ && r_i == 8'hFF) begin
                r_i1   <= '0;
                r_i2   <= '0;
                r_done <= 1'b1;
            end
            if (r_state == ST_PRD2) begin
                r_i2 <= w_i2_next;
            end
            if (w_fin_fire && r_last) begin
                r_done <= 1'b0;
            end

            if (w_fin_fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers and output payload.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && w_in_xfer) begin
            r_data <= s_axis_tdata;
            r_last <= s_axis_tlast;
            r_j    <= '0;
            r_s    <= '0;
        end
        if (r_state == ST_KRJ) begin
            r_a <= ram_rdata;
            r_j <= w_j_next;
        end
        if (r_state == ST_KWJ) begin
            r_s <= w_s_wrap ? '0 : SW'(r_s + 1'b1);
        end
        if (r_state == ST_PRD2) begin
            r_a <= ram_rdata;
        end
        if (r_state == ST_SWAP) begin
            r_b <= ram_rdata;
            r_t <= w_t;
        end
        if (w_fin_fire) begin
            r_out_data <= r_data ^ w_ks;
            r_out_last <= r_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    // The table is only written while a byte or a key schedule is at work.
    `ASSERT_CLK(a_no_write_idle, (r_state == ST_IDLE) |-> !ram_we,
        "table written while idle")

    // An input transfer always starts work on the next cycle.
    `ASSERT_CLK(a_xfer_leaves_idle, (s_axis_tvalid && s_axis_tready) |=> (r_state != ST_IDLE),
        "input transfer did not start processing")

    // A new result appears only as the last step of a byte.
    `ASSERT_CLK(a_result_from_fin, $rose(r_out_valid) |-> $past(r_state == ST_FIN),
        "result raised outside the final step")

    // Index one and index two are cleared whenever a key schedule completes.
    `ASSERT_CLK(a_sched_clears_i1, (r_state == ST_PRD1) |-> (r_i1 == 8'd0 && r_i2 == 8'd0),
        "indices not cleared after key schedule")

endmodule

@@ rtl/rc4fb_ram.sv @@
// ----------------------------------------------------------------------------
// rc4fb_ram
// Generic memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module rc4fb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
